// ===== rtl/tahl_pkg.sv =====
// ----------------------------------------------------------------------------
// tahl_pkg
// Shared types and constants of the temperature alarm and hysteresis logger.
// ----------------------------------------------------------------------------
package tahl_pkg;

    // queue depths between the parts
    localparam int MQ_DEPTH  = 4;
    localparam int OUT_DEPTH = 4;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] CFG_IDX_ALARM   = 2'd0;
    localparam logic [1:0] CFG_IDX_RELEASE = 2'd1;
    localparam logic [1:0] CFG_IDX_BLINK   = 2'd2;

    localparam logic signed [7:0] ALARM_THRESHOLD_RST   = 8'sd28;
    localparam logic signed [7:0] RELEASE_THRESHOLD_RST = 8'sd25;
    localparam logic [15:0]       BLINK_PERIOD_RST      = 16'd100;

    // request kinds
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // temperature conversion: 100 - 165 * adc / full scale
    localparam int TEMP_OFFSET    = 100;
    localparam int TEMP_SPAN      = 165;
    localparam int TEMP_DIV_SHIFT = 39;

    // exact floor(x / 1000) for any 32-bit x
    localparam logic [31:0] MS_TO_S_MAGIC = 32'h10624DD3;
    localparam int          MS_TO_S_SHIFT = 38;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] adc_sample;
        logic [31:0] now_ms;
        logic [6:0]  stamp_year;
        logic [3:0]  stamp_month;
        logic [4:0]  stamp_day;
        logic [4:0]  stamp_hour;
        logic [5:0]  stamp_minute;
        logic [5:0]  stamp_second;
        logic [5:0]  entry_index;
    } item_t;

    typedef struct packed {
        logic signed [7:0] temperature;
        logic              alarm_active;
        logic              led_on;
        logic [6:0]        alarm_count;
        logic signed [7:0] entry_threshold;
        logic [6:0]        entry_year;
        logic [3:0]        entry_month;
        logic [4:0]        entry_day;
        logic [4:0]        entry_hour;
        logic [5:0]        entry_minute;
        logic [5:0]        entry_second;
        logic [22:0]       entry_duration_s;
    } result_t;

    // classified item between front and back
    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [7:0] temperature;
        logic [31:0]       now_ms;
        logic [6:0]        stamp_year;
        logic [3:0]        stamp_month;
        logic [4:0]        stamp_day;
        logic [4:0]        stamp_hour;
        logic [5:0]        stamp_minute;
        logic [5:0]        stamp_second;
        logic [5:0]        entry_index;
    } mq_item_t;

    // one history stamp entry
    typedef struct packed {
        logic signed [7:0] threshold;
        logic [6:0]        year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } stamp_t;

    typedef struct packed {
        logic signed [7:0] alarm_threshold;
        logic signed [7:0] release_threshold;
        logic [15:0]       blink_period_ms;
    } cfg_t;

endpackage

// ===== rtl/tahl_ram.sv =====
// ----------------------------------------------------------------------------
// tahl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tahl_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tahl_fifo.sv =====
// ----------------------------------------------------------------------------
// tahl_fifo
// Small register queue with occupancy count, used between the parts.
// ----------------------------------------------------------------------------
module tahl_fifo #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 4,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/tahl_front.sv =====
// ----------------------------------------------------------------------------
// tahl_front
// Accepts request beats, converts the converter reading to whole degrees
// and hands classified items to the middle queue.
// ----------------------------------------------------------------------------
module tahl_front #(
    parameter int  ADC_FULL_SCALE = 4095,
    parameter int  Q_DEPTH        = 4,
    localparam int QCW            = $clog2(Q_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tahl_pkg::item_t     item,
    input  logic [QCW-1:0]      q_count,
    output logic                q_push,
    output tahl_pkg::mq_item_t  q_item
);

    import tahl_pkg::*;

    // ceil(2^39 / full scale) gives an exact floor for 23-bit dividends
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << TEMP_DIV_SHIFT) + longint'(ADC_FULL_SCALE) - 1) / longint'(ADC_FULL_SCALE);
    localparam logic [31:0] RECIP    = 32'(RECIP_FULL);
    localparam logic [23:0] NUM_BASE = 24'(TEMP_OFFSET * ADC_FULL_SCALE);

    logic               accept;
    logic [19:0]        scaled;
    logic signed [24:0] num;
    logic               num_neg;
    logic [22:0]        num_mag;

    logic               f1_valid_reg;
    item_t              f1_item_reg;
    logic               f1_neg_reg;
    logic [22:0]        f1_mag_reg;
    logic [54:0]        f1_prod;

    logic               f2_valid_reg;
    item_t              f2_item_reg;
    logic               f2_neg_reg;
    logic [15:0]        f2_quot_reg;
    logic signed [7:0]  f2_temp;

    assign full   = (int'(q_count) + int'(f1_valid_reg) + int'(f2_valid_reg)) >= Q_DEPTH;
    assign accept = push && !full;

    // numerator of the conversion, then sign and magnitude
    assign scaled  = 20'(item.adc_sample) * 20'(TEMP_SPAN);
    assign num     = $signed({1'b0, NUM_BASE}) - $signed({5'd0, scaled});
    assign num_neg = num[24];
    assign num_mag = num_neg ? 23'(-num) : num[22:0];

    assign f1_prod = f1_mag_reg * RECIP;

    // truncate toward zero, then saturate to 8 bits
    always_comb
    begin
        if (f2_item_reg.req_type != REQ_SAMPLE)
        begin
            f2_temp = '0;
        end
        else if (f2_neg_reg)
        begin
            f2_temp = (f2_quot_reg > 16'd128) ? -8'sd128 : $signed(8'(8'd0 - f2_quot_reg[7:0]));
        end
        else
        begin
            f2_temp = (f2_quot_reg > 16'd127) ? 8'sd127 : $signed(f2_quot_reg[7:0]);
        end
    end

    always_comb
    begin
        q_item.req_type     = f2_item_reg.req_type;
        q_item.temperature  = f2_temp;
        q_item.now_ms       = f2_item_reg.now_ms;
        q_item.stamp_year   = f2_item_reg.stamp_year;
        q_item.stamp_month  = f2_item_reg.stamp_month;
        q_item.stamp_day    = f2_item_reg.stamp_day;
        q_item.stamp_hour   = f2_item_reg.stamp_hour;
        q_item.stamp_minute = f2_item_reg.stamp_minute;
        q_item.stamp_second = f2_item_reg.stamp_second;
        q_item.entry_index  = f2_item_reg.entry_index;
    end

    assign q_push = f2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_item_reg <= item;
        f1_neg_reg  <= num_neg;
        f1_mag_reg  <= num_mag;
        f2_item_reg <= f1_item_reg;
        f2_neg_reg  <= f1_neg_reg;
        f2_quot_reg <= 16'(f1_prod >> TEMP_DIV_SHIFT);
    end

endmodule

// ===== rtl/tahl_back.sv =====
// ----------------------------------------------------------------------------
// tahl_back
// Runs the hysteresis alarm, LED blink and onset history for each item and
// assembles the result beat, reading the history through a short pipeline.
// ----------------------------------------------------------------------------
module tahl_back #(
    parameter int  HISTORY_DEPTH = 64,
    parameter int  OUT_DEPTH     = 4,
    localparam int OCW           = $clog2(OUT_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tahl_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  tahl_pkg::mq_item_t q_item,
    output logic               q_pop,
    input  logic [OCW-1:0]     out_count,
    output logic               out_push,
    output tahl_pkg::result_t  out_item
);

    import tahl_pkg::*;

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    typedef struct packed {
        logic signed [7:0] temperature;
        logic              alarm_active;
        logic              led_on;
        logic [6:0]        alarm_count;
        logic              rd_valid;
    } status_t;

    logic              alarm_reg;
    logic              alarm_next;
    logic              led_reg;
    logic              led_next;
    logic [31:0]       blink_start_reg;
    logic [31:0]       blink_start_next;
    logic [31:0]       alarm_start_reg;
    logic [31:0]       alarm_start_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              onset_reg;
    logic              onset_next;

    logic              issue;
    logic              rising_dir;
    logic              set_cond;
    logic              clr_cond;
    logic [31:0]       alarm_elapsed;
    logic [31:0]       blink_elapsed;

    logic              stamp_we;
    stamp_t            stamp_wdata;
    logic              dur_we;
    logic [IDX_W-1:0]  dur_waddr;
    logic [31:0]       dur_wdata;
    logic [IDX_W-1:0]  rd_addr;
    status_t           status;

    logic [$bits(stamp_t)-1:0] stamp_rdata;
    logic [31:0]       dur_rdata;
    logic [63:0]       dur_prod;

    logic              b1_valid_reg;
    status_t           b1_status_reg;
    logic              b2_valid_reg;
    status_t           b2_status_reg;
    stamp_t            b2_stamp_reg;
    logic [22:0]       b2_dur_reg;

    // credit check keeps the result queue from overflowing
    assign issue = !q_empty &&
                   ((int'(out_count) + int'(b1_valid_reg) + int'(b2_valid_reg)) < OUT_DEPTH);
    assign q_pop = issue;

    assign rising_dir = cfg.alarm_threshold > cfg.release_threshold;
    assign set_cond   = rising_dir ? (q_item.temperature >= cfg.alarm_threshold)
                                   : (q_item.temperature <= cfg.alarm_threshold);
    assign clr_cond   = rising_dir ? (q_item.temperature <= cfg.release_threshold)
                                   : (q_item.temperature >= cfg.release_threshold);

    assign alarm_elapsed = q_item.now_ms - alarm_start_reg;
    assign blink_elapsed = q_item.now_ms - blink_start_reg;
    assign rd_addr       = IDX_W'(q_item.entry_index);

    always_comb
    begin
        stamp_wdata.threshold = cfg.alarm_threshold;
        stamp_wdata.year      = q_item.stamp_year;
        stamp_wdata.month     = q_item.stamp_month;
        stamp_wdata.day       = q_item.stamp_day;
        stamp_wdata.hour      = q_item.stamp_hour;
        stamp_wdata.minute    = q_item.stamp_minute;
        stamp_wdata.second    = q_item.stamp_second;
    end

    always_comb
    begin
        alarm_next       = alarm_reg;
        led_next         = led_reg;
        blink_start_next = blink_start_reg;
        alarm_start_next = alarm_start_reg;
        count_next       = count_reg;
        onset_next       = onset_reg;
        stamp_we         = 1'b0;
        dur_we           = 1'b0;
        dur_waddr        = IDX_W'(count_reg);
        dur_wdata        = '0;
        status.rd_valid  = 1'b0;
        if (issue)
        begin
            case (q_item.req_type)
                REQ_SAMPLE:
                begin
                    if (set_cond)
                    begin
                        if (!alarm_reg)
                        begin
                            alarm_start_next = q_item.now_ms;
                            if (count_reg < CNT_W'(HISTORY_DEPTH))
                            begin
                                stamp_we   = 1'b1;
                                dur_we     = 1'b1;
                                count_next = CNT_W'(count_reg + 1'b1);
                                onset_next = 1'b1;
                            end
                            else
                            begin
                                onset_next = 1'b0;
                            end
                        end
                        alarm_next = 1'b1;
                    end
                    else if (clr_cond)
                    begin
                        // stored in ms, turned into seconds on the read path
                        if (alarm_reg && onset_reg && (count_reg != '0))
                        begin
                            dur_we    = 1'b1;
                            dur_waddr = IDX_W'(count_reg - 1'b1);
                            dur_wdata = alarm_elapsed;
                        end
                        alarm_next = 1'b0;
                        onset_next = 1'b0;
                    end
                    if (alarm_next)
                    begin
                        if (blink_elapsed >= 32'(cfg.blink_period_ms))
                        begin
                            led_next         = !led_reg;
                            blink_start_next = q_item.now_ms;
                        end
                    end
                    else
                    begin
                        led_next = 1'b0;
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                    onset_next = 1'b0;
                end
                REQ_READ:
                begin
                    status.rd_valid = int'(q_item.entry_index) < int'(count_reg);
                end
                default:
                begin
                end
            endcase
        end
        status.temperature  = q_item.temperature;
        status.alarm_active = alarm_next;
        status.led_on       = led_next;
        status.alarm_count  = 7'(count_next);
    end

    tahl_ram #(
        .WIDTH ($bits(stamp_t)),
        .DEPTH (HISTORY_DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (IDX_W'(count_reg)),
        .wdata (stamp_wdata),
        .raddr (rd_addr),
        .rdata (stamp_rdata)
    );

    tahl_ram #(
        .WIDTH (32),
        .DEPTH (HISTORY_DEPTH)
    ) u_dur_ram (
        .clk   (clk),
        .we    (dur_we),
        .waddr (dur_waddr),
        .wdata (dur_wdata),
        .raddr (rd_addr),
        .rdata (dur_rdata)
    );

    assign dur_prod = dur_rdata * MS_TO_S_MAGIC;

    always_comb
    begin
        out_item.temperature  = b2_status_reg.temperature;
        out_item.alarm_active = b2_status_reg.alarm_active;
        out_item.led_on       = b2_status_reg.led_on;
        out_item.alarm_count  = b2_status_reg.alarm_count;
        if (b2_status_reg.rd_valid)
        begin
            out_item.entry_threshold  = b2_stamp_reg.threshold;
            out_item.entry_year       = b2_stamp_reg.year;
            out_item.entry_month      = b2_stamp_reg.month;
            out_item.entry_day        = b2_stamp_reg.day;
            out_item.entry_hour       = b2_stamp_reg.hour;
            out_item.entry_minute     = b2_stamp_reg.minute;
            out_item.entry_second     = b2_stamp_reg.second;
            out_item.entry_duration_s = b2_dur_reg;
        end
        else
        begin
            out_item.entry_threshold  = '0;
            out_item.entry_year       = '0;
            out_item.entry_month      = '0;
            out_item.entry_day        = '0;
            out_item.entry_hour       = '0;
            out_item.entry_minute     = '0;
            out_item.entry_second     = '0;
            out_item.entry_duration_s = '0;
        end
    end

    assign out_push = b2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg       <= 1'b0;
            led_reg         <= 1'b0;
            blink_start_reg <= '0;
            alarm_start_reg <= '0;
            count_reg       <= '0;
            onset_reg       <= 1'b0;
            b1_valid_reg    <= 1'b0;
            b2_valid_reg    <= 1'b0;
        end
        else
        begin
            alarm_reg       <= alarm_next;
            led_reg         <= led_next;
            blink_start_reg <= blink_start_next;
            alarm_start_reg <= alarm_start_next;
            count_reg       <= count_next;
            onset_reg       <= onset_next;
            b1_valid_reg    <= issue;
            b2_valid_reg    <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_status_reg <= status;
        b2_status_reg <= b1_status_reg;
        b2_stamp_reg  <= stamp_rdata;
        b2_dur_reg    <= 23'(dur_prod >> MS_TO_S_SHIFT);
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= HISTORY_DEPTH)
        else $error("history count beyond depth");

    a_led_needs_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg |-> alarm_reg)
        else $error("led lit without alarm");

    a_onset_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        onset_reg |-> (alarm_reg && (count_reg != '0)))
        else $error("logged onset without alarm or entry");
`endif

endmodule

// ===== rtl/temperature_alarm_hysteresis_logger_top.sv =====
// ----------------------------------------------------------------------------
// temperature_alarm_hysteresis_logger_top
// Temperature alarm with hysteresis, blinking LED and onset history log.
// ----------------------------------------------------------------------------
// path: an accepted request passes the front stages, the middle queue, the back stages and the result queue
// throughput: one request per cycle while full is low; the alarm state updates for
//   each issued item, and the history RAMs take one write and one read per cycle
// reset: asynchronous, active low; clears alarm, LED, counts and configuration registers
//   to their defaults; history RAM contents are undefined until written
module temperature_alarm_hysteresis_logger_top #(
    parameter int HISTORY_DEPTH  = 64,
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  tahl_pkg::item_t                      item,
    output logic                                 empty,
    input  logic                                 pop,
    output tahl_pkg::result_t                    result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tahl_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tahl_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tahl_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    import tahl_pkg::*;

    localparam int MQCW  = $clog2(MQ_DEPTH + 1);
    localparam int OUTCW = $clog2(OUT_DEPTH + 1);

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic               cfg_we;
    logic [1:0]         cfg_index;

    logic               mq_push;
    mq_item_t           mq_wdata;
    mq_item_t           mq_head;
    logic               mq_pop;
    logic               mq_empty;
    logic [MQCW-1:0]    mq_count;

    logic               out_push;
    result_t            out_item;
    logic [OUTCW-1:0]   out_count;

    assign pready    = 1'b1;
    assign cfg_index = paddr[APB_ADDR_W-1:2];
    assign cfg_we    = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_ALARM:   cfg_next.alarm_threshold   = pwdata[7:0];
                CFG_IDX_RELEASE: cfg_next.release_threshold = pwdata[7:0];
                CFG_IDX_BLINK:   cfg_next.blink_period_ms   = pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            CFG_IDX_ALARM:   prdata = {24'd0, cfg_reg.alarm_threshold};
            CFG_IDX_RELEASE: prdata = {24'd0, cfg_reg.release_threshold};
            CFG_IDX_BLINK:   prdata = {16'd0, cfg_reg.blink_period_ms};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{alarm_threshold:   ALARM_THRESHOLD_RST,
                         release_threshold: RELEASE_THRESHOLD_RST,
                         blink_period_ms:   BLINK_PERIOD_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tahl_front #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE),
        .Q_DEPTH        (MQ_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_count (mq_count),
        .q_push  (mq_push),
        .q_item  (mq_wdata)
    );

    tahl_fifo #(
        .WIDTH ($bits(mq_item_t)),
        .DEPTH (MQ_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mq_push),
        .wdata (mq_wdata),
        .full  (),
        .pop   (mq_pop),
        .rdata (mq_head),
        .empty (mq_empty),
        .count (mq_count)
    );

    tahl_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .OUT_DEPTH     (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (mq_empty),
        .q_item    (mq_head),
        .q_pop     (mq_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    tahl_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .full  (),
        .pop   (pop),
        .rdata (result),
        .empty (empty),
        .count (out_count)
    );

`ifndef NO_ASSERTIONS
    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mq_push |-> (int'(mq_count) < MQ_DEPTH))
        else $error("middle queue overflow");

    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (int'(out_count) < OUT_DEPTH))
        else $error("result queue overflow");

    a_full_when_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(mq_count) == MQ_DEPTH) |-> full)
        else $error("input open while middle queue full");
`endif

endmodule
